// ----- rtl/core/mfq_pkg.sv -----
// ----------------------------------------------------------------------------
// mfq_pkg
// Shared types and codes of the multilevel feedback queue scheduler.
// ----------------------------------------------------------------------------
package mfq_pkg;

	localparam int QUEUE_DEPTH_DEF = 128;
	localparam int LEVELS_DEF      = 3;

	localparam int TASK_W  = 8;
	localparam int LEVEL_W = 2;
	localparam int COUNT_W = 8;

	typedef enum logic [1:0] {
		ACT_ADMIT    = 2'd0,
		ACT_DISPATCH = 2'd1,
		ACT_REPORT   = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		OUT_QUANTUM = 2'd0,
		OUT_IO      = 2'd1,
		OUT_HALT    = 2'd2
	} outcome_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_FULL    = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	// one result as it leaves the decision stage
	typedef struct packed {
		logic [TASK_W-1:0]  task_id;
		logic               from_mem;
		logic [LEVEL_W-1:0] level;
		logic [1:0]         status;
		logic [COUNT_W-1:0] completed;
		logic               all_done;
	} res_t;

endpackage

// ----- rtl/core/mfq_queue_mem.sv -----
// ----------------------------------------------------------------------------
// mfq_queue_mem
// Task store for all levels: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mfq_queue_mem #(
	parameter int WORDS = 384,
	parameter int AW    = 9,
	parameter int DW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/mfq_ctrl.sv -----
// ----------------------------------------------------------------------------
// mfq_ctrl
// Scheduler decision logic: level pointers, running task, retired count.
// ----------------------------------------------------------------------------
module mfq_ctrl #(
	parameter int QUEUE_DEPTH = mfq_pkg::QUEUE_DEPTH_DEF,
	parameter int LEVELS      = mfq_pkg::LEVELS_DEF,
	parameter int AW          = 9
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  logic [1:0]             action,
	input  logic [mfq_pkg::TASK_W-1:0]  task_id,
	input  logic [1:0]             outcome,
	input  logic [mfq_pkg::COUNT_W-1:0] task_total,
	input  logic [mfq_pkg::TASK_W-1:0]  mem_rdata,
	output logic                   mem_we,
	output logic [AW-1:0]          mem_waddr,
	output logic [mfq_pkg::TASK_W-1:0]  mem_wdata,
	output logic                   mem_re,
	output logic [AW-1:0]          mem_raddr,
	output mfq_pkg::res_t          res
);
	import mfq_pkg::*;

	localparam int IW  = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int LVW = $clog2(LEVELS);

	logic [IW-1:0]      head_q  [LEVELS];
	logic [IW-1:0]      tail_q  [LEVELS];
	logic [CW-1:0]      count_q [LEVELS];
	logic [TASK_W-1:0]  running_task_q;
	logic [LVW-1:0]     running_lv_q;
	logic               running_valid_q;
	logic               run_from_mem_q;
	logic [COUNT_W-1:0] retired_q;

	logic [TASK_W-1:0]  run_task;
	logic [LVW-1:0]     pick_lv;
	logic               found;
	logic [LVW-1:0]     demote_lv;
	logic [LVW-1:0]     push_lv;
	logic [TASK_W-1:0]  push_id;
	logic               push_req;
	logic               pop_req;
	logic               retire;
	logic               run_clr;
	logic [COUNT_W-1:0] retired_nxt;
	logic [LEVELS-1:0]  full;

	function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx);
		next_idx = (idx == IW'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
	endfunction

	function automatic logic [AW-1:0] base_addr(input logic [LVW-1:0] lv);
		base_addr = AW'(lv) * AW'(QUEUE_DEPTH);
	endfunction

	// a task just popped is still in the memory read register
	assign run_task = run_from_mem_q ? mem_rdata : running_task_q;

	always_comb begin
		for (int l = 0; l < LEVELS; l++) begin
			full[l] = (count_q[l] == CW'(QUEUE_DEPTH));
		end
	end

	always_comb begin
		found   = 1'b0;
		pick_lv = '0;
		for (int l = LEVELS - 1; l >= 0; l--) begin
			if (count_q[l] != '0) begin
				found   = 1'b1;
				pick_lv = LVW'(l);
			end
		end
	end

	assign demote_lv = (running_lv_q == LVW'(LEVELS - 1)) ? running_lv_q
		: running_lv_q + 1'b1;

	always_comb begin
		res         = '0;
		res.status  = ST_INVALID;
		push_req    = 1'b0;
		push_lv     = '0;
		push_id     = task_id;
		pop_req     = 1'b0;
		retire      = 1'b0;
		run_clr     = 1'b0;
		case (action)
			ACT_ADMIT: begin
				res.task_id = task_id;
				if (!full[0]) begin
					push_req   = 1'b1;
					res.status = ST_OK;
				end else begin
					res.status = ST_FULL;
				end
			end
			ACT_DISPATCH: begin
				if (running_valid_q) begin
					res.task_id = run_task;
					res.level   = LEVEL_W'(running_lv_q);
				end else if (found) begin
					pop_req      = 1'b1;
					res.from_mem = 1'b1;
					res.level    = LEVEL_W'(pick_lv);
					res.status   = ST_OK;
				end else begin
					res.status = ST_EMPTY;
				end
			end
			ACT_REPORT: begin
				if (running_valid_q) begin
					res.task_id = run_task;
					res.level   = LEVEL_W'(running_lv_q);
					case (outcome) inside
						OUT_HALT: begin
							retire     = 1'b1;
							run_clr    = 1'b1;
							res.status = ST_OK;
						end
						OUT_QUANTUM, OUT_IO: begin
							push_lv   = (outcome == OUT_QUANTUM) ? demote_lv : running_lv_q;
							push_id   = run_task;
							run_clr   = 1'b1;
							res.level = LEVEL_W'(push_lv);
							if (!full[push_lv]) begin
								push_req   = 1'b1;
								res.status = ST_OK;
							end else begin
								res.status = ST_FULL;
							end
						end
						default: res.status = ST_INVALID;
					endcase
				end
			end
			default: res.status = ST_INVALID;
		endcase
		retired_nxt   = (retire && retired_q != '1) ? retired_q + 1'b1 : retired_q;
		res.completed = retired_nxt;
		res.all_done  = (retired_nxt == task_total);
	end

	assign mem_we    = fire && push_req;
	assign mem_waddr = base_addr(push_lv) + AW'(tail_q[push_lv]);
	assign mem_wdata = push_id;
	assign mem_re    = fire && pop_req;
	assign mem_raddr = base_addr(pick_lv) + AW'(head_q[pick_lv]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LEVELS; l++) begin
				head_q[l]  <= '0;
				tail_q[l]  <= '0;
				count_q[l] <= '0;
			end
			running_task_q  <= '0;
			running_lv_q    <= '0;
			running_valid_q <= 1'b0;
			run_from_mem_q  <= 1'b0;
			retired_q       <= '0;
		end else begin
			if (run_from_mem_q) begin
				running_task_q <= mem_rdata;
				run_from_mem_q <= 1'b0;
			end
			if (fire) begin
				retired_q <= retired_nxt;
				if (push_req) begin
					tail_q[push_lv]  <= next_idx(tail_q[push_lv]);
					count_q[push_lv] <= count_q[push_lv] + 1'b1;
				end
				if (pop_req) begin
					head_q[pick_lv]  <= next_idx(head_q[pick_lv]);
					count_q[pick_lv] <= count_q[pick_lv] - 1'b1;
					running_lv_q     <= pick_lv;
					running_valid_q  <= 1'b1;
					run_from_mem_q   <= 1'b1;
				end
				if (run_clr) begin
					running_valid_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ----- rtl/core/multilevel_feedback_queue_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler_top
// Three-level feedback queue scheduler over 8-bit task identifiers.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries action, task_id and outcome:
// admit a task to level 0, dispatch the oldest task of the lowest-numbered
// busy level, or report the running task's slice outcome. Output channel
// (out_valid / out_stall) returns exactly one result per input transaction:
// task_id_out, level, status, completed_count and all_done.
// cfg_valid / cfg_ready writes task_total; cfg_ready is always high. The user
// must write the register only while no transaction is in flight; the block
// itself does not enforce it. From acceptance to out_valid a transaction
// passes the input register and then the result register: the decision runs
// and the task store is read while it sits in the input register, and the
// result register drives the outputs. One transaction is accepted per cycle
// while out_stall does not hold the result register; the rate holds because
// the decision finishes in the input register, the store read register
// loading on the same edge as the result register.
// When out_stall is high the result register holds, a transaction in the input
// register holds behind it and in_stall rises, so nothing is lost.
// Reset clears all queue pointers, counts, the running task and the retired
// count at once; the task store itself is not cleared.
// ----------------------------------------------------------------------------
module multilevel_feedback_queue_scheduler_top #(
	parameter int QUEUE_DEPTH = mfq_pkg::QUEUE_DEPTH_DEF,
	parameter int LEVELS      = mfq_pkg::LEVELS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   action,
	input  logic [mfq_pkg::TASK_W-1:0]   task_id,
	input  logic [1:0]                   outcome,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [mfq_pkg::TASK_W-1:0]   task_id_out,
	output logic [mfq_pkg::LEVEL_W-1:0]  level,
	output logic [1:0]                   status,
	output logic [mfq_pkg::COUNT_W-1:0]  completed_count,
	output logic                         all_done,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [mfq_pkg::COUNT_W-1:0]  cfg_data
);
	import mfq_pkg::*;

	localparam int WORDS = LEVELS * QUEUE_DEPTH;
	localparam int AW    = $clog2(WORDS);

	logic               valid_s1;
	logic [1:0]         action_s1;
	logic [TASK_W-1:0]  task_id_s1;
	logic [1:0]         outcome_s1;
	logic               valid_s2;
	res_t               res_s2;
	res_t               res;
	logic               adv1;
	logic               in_fire;
	logic [COUNT_W-1:0] task_total_q;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [TASK_W-1:0]  mem_wdata;
	logic               mem_re;
	logic [AW-1:0]      mem_raddr;
	logic [TASK_W-1:0]  mem_rdata;

	assign adv1     = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv1;
	assign in_fire  = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			task_total_q <= '0;
		end else begin
			valid_s1 <= in_fire || (valid_s1 && !adv1);
			valid_s2 <= adv1 || (valid_s2 && out_stall);
			if (cfg_valid) begin
				task_total_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			action_s1  <= action;
			task_id_s1 <= task_id;
			outcome_s1 <= outcome;
		end
		if (adv1) begin
			res_s2 <= res;
		end
	end

	mfq_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.LEVELS     (LEVELS),
		.AW         (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (adv1),
		.action    (action_s1),
		.task_id   (task_id_s1),
		.outcome   (outcome_s1),
		.task_total(task_total_q),
		.mem_rdata (mem_rdata),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.res       (res)
	);

	mfq_queue_mem #(
		.WORDS(WORDS),
		.AW   (AW),
		.DW   (TASK_W)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// a dispatched task arrives from the store read register
	assign out_valid       = valid_s2;
	assign task_id_out     = res_s2.from_mem ? mem_rdata : res_s2.task_id;
	assign level           = res_s2.level;
	assign status          = res_s2.status;
	assign completed_count = res_s2.completed;
	assign all_done        = res_s2.all_done;

endmodule

// ----- rtl/core/mfq_checker.sv -----
// ----------------------------------------------------------------------------
// mfq_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module mfq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] task_id_out,
	input logic [1:0] level,
	input logic [1:0] status,
	input logic [7:0] completed_count
);
	import mfq_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(task_id_out) && $stable(status))
		else $error("stalled result changed");

	// with the result register empty the input side always takes a transaction
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> task_id_out == 8'd0 && level == 2'd0)
		else $error("empty dispatch carries a task");

	// the retired count never goes back between successive results
	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall ##1 out_valid |-> completed_count >= $past(completed_count))
		else $error("completed count decreased");

endmodule

bind multilevel_feedback_queue_scheduler_top mfq_checker u_mfq_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.task_id_out    (task_id_out),
	.level          (level),
	.status         (status),
	.completed_count(completed_count)
);

// ----- verif/multilevel_feedback_queue_scheduler_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler_top_test
// Drives admit, dispatch and report transactions into the scheduler under
// random sender bursts and receiver stalls. Every result is checked against
// a cycle-free scheduler predictor. The run writes task_total between phases.
// ----------------------------------------------------------------------------
module multilevel_feedback_queue_scheduler_top_test;
	import mfq_pkg::*;

	localparam int QDEPTH     = QUEUE_DEPTH_DEF;
	localparam int NLEVELS    = LEVELS_DEF;
	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_WAIT = 4;

	// codes outside the package enums
	localparam logic [1:0] ACT_BAD = 2'd3;
	localparam logic [1:0] OUT_BAD = 2'd3;

	typedef enum int {PACE_FREE, PACE_LIGHT, PACE_HEAVY, PACE_PATTERN} pace_t;

	typedef struct packed {
		logic [1:0]        act;
		logic [TASK_W-1:0] id;
		logic [1:0]        oc;
	} sched_order_t;

	typedef struct packed {
		logic [TASK_W-1:0]  task_id;
		logic [LEVEL_W-1:0] level;
		logic [1:0]         status;
		logic [COUNT_W-1:0] completed;
		logic               done;
	} sched_decision_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] action = ACT_ADMIT;
	logic [TASK_W-1:0] task_id = '0;
	logic [1:0] outcome = OUT_QUANTUM;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [TASK_W-1:0] task_id_out;
	logic [LEVEL_W-1:0] level;
	logic [1:0] status;
	logic [COUNT_W-1:0] completed_count;
	logic all_done;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [COUNT_W-1:0] cfg_data = '0;

	multilevel_feedback_queue_scheduler_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.task_id         (task_id),
		.outcome         (outcome),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.task_id_out     (task_id_out),
		.level           (level),
		.status          (status),
		.completed_count (completed_count),
		.all_done        (all_done),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data)
	);

	// scheduler state as the testbench sees it
	logic [TASK_W-1:0] ready_mem[NLEVELS*QDEPTH];
	int ready_head[NLEVELS];
	int ready_tail[NLEVELS];
	int ready_cnt[NLEVELS];
	logic [TASK_W-1:0] run_task;
	int run_level;
	bit run_valid;
	int retired;
	logic [COUNT_W-1:0] job_total;

	sched_order_t sched_orders[$];
	sched_decision_t pending_decisions[$];
	int orders_issued;
	int decisions_seen;
	int errors;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit ready_push(input int lv, input logic [TASK_W-1:0] id);
		if (ready_cnt[lv] >= QDEPTH)
			return 1'b0;
		ready_mem[lv*QDEPTH + ready_tail[lv]] = id;
		ready_tail[lv] = (ready_tail[lv] + 1) % QDEPTH;
		ready_cnt[lv]++;
		return 1'b1;
	endfunction

	function automatic sched_decision_t next_decision(input sched_order_t o);
		sched_decision_t d;
		int lv;
		bit found;
		d = '0;
		d.status = ST_INVALID;
		found = 1'b0;
		case (o.act)
		ACT_ADMIT: begin
			d.task_id = o.id;
			d.status = ready_push(0, o.id) ? ST_OK : ST_FULL;
		end
		ACT_DISPATCH: begin
			if (run_valid) begin
				d.task_id = run_task;
				d.level = run_level[LEVEL_W-1:0];
			end else begin
				d.status = ST_EMPTY;
				for (lv = 0; lv < NLEVELS; lv++) begin
					if (!found && ready_cnt[lv] != 0) begin
						found = 1'b1;
						run_task = ready_mem[lv*QDEPTH + ready_head[lv]];
						ready_head[lv] = (ready_head[lv] + 1) % QDEPTH;
						ready_cnt[lv]--;
						run_level = lv;
						run_valid = 1'b1;
						d.task_id = run_task;
						d.level = lv[LEVEL_W-1:0];
						d.status = ST_OK;
					end
				end
			end
		end
		ACT_REPORT: begin
			if (run_valid && o.oc == OUT_BAD) begin
				d.task_id = run_task;
				d.level = run_level[LEVEL_W-1:0];
			end else if (run_valid && o.oc == OUT_HALT) begin
				d.task_id = run_task;
				d.level = run_level[LEVEL_W-1:0];
				d.status = ST_OK;
				if (retired < 255)
					retired++;
				run_valid = 1'b0;
			end else if (run_valid) begin
				lv = run_level;
				// full quantum sinks one level, the lowest level keeps it
				if (o.oc == OUT_QUANTUM && lv + 1 < NLEVELS)
					lv++;
				d.task_id = run_task;
				d.level = lv[LEVEL_W-1:0];
				d.status = ready_push(lv, run_task) ? ST_OK : ST_FULL;
				run_valid = 1'b0;
			end
		end
		default: ;
		endcase
		d.completed = retired[COUNT_W-1:0];
		d.done = (retired == int'(job_total));
		return d;
	endfunction

	task automatic flag_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	// sender: bursts of random length with random gaps between them
	int burst_left = 0;
	int gap_left = 0;
	sched_order_t cur_order;

	always @(posedge clk) begin
		logic take;
		logic nxt_valid;
		take = in_valid && !in_stall;
		nxt_valid = in_valid && !take;
		if (take)
			pending_decisions.push_back(next_decision(cur_order));
		if (arst_n && !nxt_valid) begin
			if (gap_left != 0) begin
				gap_left--;
			end else if (sched_orders.size() != 0) begin
				cur_order = sched_orders.pop_front();
				nxt_valid = 1'b1;
				if (burst_left != 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
				end
			end
		end
		in_valid <= nxt_valid;
		if (nxt_valid) begin
			action <= cur_order.act;
			task_id <= cur_order.id;
			outcome <= cur_order.oc;
		end
	end

	// receiver: stall behavior switches between a few paces
	pace_t pace = PACE_FREE;
	int pace_left = 0;
	logic [7:0] pace_bits = '0;

	always @(posedge clk) begin
		if (pace_left == 0) begin
			pace = pace_t'($urandom_range(0, 3));
			pace_left = $urandom_range(16, 128);
			pace_bits = 8'($urandom);
			pace_bits[0] = 1'b0;
		end
		pace_left--;
		case (pace)
		PACE_FREE:    out_stall <= 1'b0;
		PACE_LIGHT:   out_stall <= ($urandom_range(0, 3) == 0);
		PACE_HEAVY:   out_stall <= ($urandom_range(0, 3) != 0);
		default:      out_stall <= pace_bits[pace_left % 8];
		endcase
	end

	always @(posedge clk) begin
		sched_decision_t got;
		sched_decision_t want;
		if (arst_n && out_valid && !out_stall) begin
			decisions_seen++;
			got.task_id = task_id_out;
			got.level = level;
			got.status = status;
			got.completed = completed_count;
			got.done = all_done;
			if (pending_decisions.size() == 0) begin
				flag_error($sformatf("result with nothing expected: task %02h level %0d status %0d",
					got.task_id, got.level, got.status));
			end else begin
				want = pending_decisions.pop_front();
				if (got.task_id !== want.task_id || got.level !== want.level ||
						got.status !== want.status || got.completed !== want.completed ||
						got.done !== want.done)
					flag_error($sformatf({"mismatch: exp task %02h level %0d status %0d ",
						"count %0d done %0b, got task %02h level %0d status %0d count %0d done %0b"},
						want.task_id, want.level, want.status, want.completed, want.done,
						got.task_id, got.level, got.status, got.completed, got.done));
			end
		end
	end

	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic add_order(input logic [1:0] a, input logic [TASK_W-1:0] id,
			input logic [1:0] oc);
		sched_order_t o;
		o.act = a;
		o.id = id;
		o.oc = oc;
		sched_orders.push_back(o);
		orders_issued++;
	endtask

	task automatic wait_drained();
		while (decisions_seen != orders_issued)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_total(input logic [COUNT_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		job_total = v;
		cfg_valid <= 1'b0;
		cfg_data <= COUNT_W'($urandom);
	endtask

	function automatic logic [1:0] pick_outcome(input int halt_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < halt_pct)
			return OUT_HALT;
		return (roll % 2 == 0) ? OUT_QUANTUM : OUT_IO;
	endfunction

	// mostly dispatch/report pairs with random content, some admits and noise
	task automatic add_mix(input int n, input int admit_pct, input int halt_pct);
		int made;
		int roll;
		made = 0;
		while (made < n) begin
			roll = $urandom_range(0, 99);
			if (roll < admit_pct) begin
				add_order(ACT_ADMIT, TASK_W'($urandom), 2'($urandom_range(0, 3)));
				made++;
			end else if (roll < 93) begin
				add_order(ACT_DISPATCH, TASK_W'($urandom), 2'($urandom_range(0, 3)));
				add_order(ACT_REPORT, TASK_W'($urandom), pick_outcome(halt_pct));
				made += 2;
			end else begin
				add_order(2'($urandom_range(0, 3)), TASK_W'($urandom),
					2'($urandom_range(0, 3)));
				made++;
			end
		end
	endtask

	function automatic logic [COUNT_W-1:0] total_near(input int ahead);
		return (retired + ahead > 255) ? 8'd255 : 8'(retired + ahead);
	endfunction

	initial begin
		int k;
		for (k = 0; k < NLEVELS*QDEPTH; k++)
			ready_mem[k] = '0;
		for (k = 0; k < NLEVELS; k++) begin
			ready_head[k] = 0;
			ready_tail[k] = 0;
			ready_cnt[k] = 0;
		end
		run_task = '0;
		run_level = 0;
		run_valid = 1'b0;
		retired = 0;
		job_total = '0;
		orders_issued = 0;
		decisions_seen = 0;
		errors = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_total(8'd0);

		// empty scheduler, bad orders, then two of three tasks through every level
		add_order(ACT_DISPATCH, 8'h5a, OUT_QUANTUM);
		add_order(ACT_REPORT, 8'h00, OUT_HALT);
		add_order(ACT_BAD, 8'hff, OUT_BAD);
		add_order(ACT_ADMIT, 8'h00, OUT_QUANTUM);
		add_order(ACT_ADMIT, 8'hff, OUT_BAD);
		add_order(ACT_ADMIT, 8'ha5, OUT_IO);
		add_order(ACT_DISPATCH, 8'h00, OUT_QUANTUM);
		add_order(ACT_DISPATCH, 8'h00, OUT_QUANTUM);
		add_order(ACT_REPORT, 8'h00, OUT_BAD);
		add_order(ACT_REPORT, 8'h00, OUT_QUANTUM);
		add_order(ACT_DISPATCH, 8'h00, OUT_QUANTUM);
		add_order(ACT_REPORT, 8'h00, OUT_IO);
		add_order(ACT_DISPATCH, 8'h00, OUT_QUANTUM);
		add_order(ACT_REPORT, 8'h00, OUT_HALT);
		add_order(ACT_DISPATCH, 8'h00, OUT_QUANTUM);
		add_order(ACT_REPORT, 8'h00, OUT_QUANTUM);
		add_order(ACT_DISPATCH, 8'h00, OUT_QUANTUM);
		add_order(ACT_REPORT, 8'h00, OUT_QUANTUM);
		add_order(ACT_DISPATCH, 8'h00, OUT_QUANTUM);
		add_order(ACT_REPORT, 8'h00, OUT_QUANTUM);
		add_order(ACT_DISPATCH, 8'h00, OUT_QUANTUM);
		add_order(ACT_REPORT, 8'h00, OUT_QUANTUM);
		add_order(ACT_DISPATCH, 8'h00, OUT_QUANTUM);
		add_order(ACT_REPORT, 8'h00, OUT_IO);
		wait_drained();

		// overfill level 0, then requeue a yielding task into the full level
		write_total(8'd255);
		for (k = 0; k < QDEPTH + 4; k++)
			add_order(ACT_ADMIT, TASK_W'($urandom), 2'($urandom_range(0, 3)));
		add_order(ACT_DISPATCH, TASK_W'($urandom), OUT_QUANTUM);
		add_order(ACT_ADMIT, TASK_W'($urandom), OUT_QUANTUM);
		add_order(ACT_REPORT, TASK_W'($urandom), OUT_IO);
		wait_drained();

		write_total(total_near(4));
		add_mix(200, 15, 25);
		wait_drained();

		write_total(8'd128);
		add_mix(150, 10, 50);
		wait_drained();

		write_total(total_near(2));
		add_mix(150, 35, 35);
		wait_drained();

		repeat (8) @(posedge clk);
		if (pending_decisions.size() != 0)
			flag_error($sformatf("%0d results never arrived", pending_decisions.size()));
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
